>>> hdl/ict_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ict_pkg: shared types and constants for the interval coverage tracker
// Field widths, operation codes and the controller/datapath signal groups.
// ----------------------------------------------------------------------------
package ict_pkg;

    localparam int OFFSET_BITS    = 40;
    localparam int END_BITS       = OFFSET_BITS + 1;
    localparam int AVAIL_BITS     = 41;
    localparam int MODE_BITS      = 2;
    localparam int MAX_RANGES_DEF = 16;

    localparam logic [MODE_BITS-1:0] MODE_ADD       = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_CONTAINS  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_AVAILABLE = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR     = 2'd3;

    typedef struct packed {
        logic load;
        logic clr_cnt;
        logic j_inc;
        logic set_i;
        logic merge;
        logic rd_en;
        logic rd_k;
        logic wr_en;
        logic wr_new;
        logic k_from_n;
        logic k_from_i1;
        logic k_dec;
        logic k_inc;
        logic cnt_inc;
        logic cnt_from_k;
        logic set_cov;
        logic set_avail;
        logic set_ovf;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 len_zero;
        logic                 j_end;
        logic                 k_eq_i;
        logic                 full;
        logic                 rd_e_lt_s;
        logic                 rd_s_le_e;
        logic                 hit_cov;
        logic                 hit_avail;
        logic                 past;
        logic                 out_busy;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> hdl/ict_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ict_if: valid/ready channels of the interval coverage tracker
// Request channel (mode, offset, length) and result channel.
// ----------------------------------------------------------------------------
interface ict_item_if;
    logic                               valid;
    logic                               ready;
    logic [ict_pkg::MODE_BITS-1:0]      mode;
    logic [ict_pkg::OFFSET_BITS-1:0]    offset;
    logic [ict_pkg::OFFSET_BITS-1:0]    length;

    modport source (output valid, output mode, output offset, output length, input ready);
    modport sink   (input valid, input mode, input offset, input length, output ready);
endinterface

interface ict_result_if;
    logic                               valid;
    logic                               ready;
    logic                               covered;
    logic [ict_pkg::AVAIL_BITS-1:0]     available_bytes;
    logic                               overflow;

    modport source (output valid, output covered, output available_bytes, output overflow,
                    input ready);
    modport sink   (input valid, input covered, input available_bytes, input overflow,
                    output ready);
endinterface
`default_nettype wire

>>> hdl/ict_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ict_datapath: range table, scan pointers and result registers
// Single-port range table with registered read, merge/compare logic and
// the output beat register.
// ----------------------------------------------------------------------------
module ict_datapath #(
    parameter int MAX_RANGES = ict_pkg::MAX_RANGES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  ict_pkg::t_dp_cmd                 i_cmd,
    output ict_pkg::t_dp_sts                 o_sts,
    input  wire [ict_pkg::MODE_BITS-1:0]     i_mode,
    input  wire [ict_pkg::OFFSET_BITS-1:0]   i_offset,
    input  wire [ict_pkg::OFFSET_BITS-1:0]   i_length,
    input  wire                              i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_covered,
    output logic [ict_pkg::AVAIL_BITS-1:0]   o_available_bytes,
    output logic                             o_overflow
);

    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int OB = ict_pkg::OFFSET_BITS;
    localparam int EB = ict_pkg::END_BITS;
    localparam int VB = ict_pkg::AVAIL_BITS;

    logic [OB-1:0] mem_start [MAX_RANGES];
    logic [EB-1:0] mem_end   [MAX_RANGES];

    logic [ict_pkg::MODE_BITS-1:0] r_mode;
    logic [OB-1:0]  r_off;
    logic [OB-1:0]  r_s;
    logic [EB-1:0]  r_e;
    logic           r_len_zero;
    logic [CW-1:0]  r_i;
    logic [CW-1:0]  r_j;
    logic [CW-1:0]  r_k;
    logic [CW-1:0]  r_cnt;
    logic [OB-1:0]  r_rd_s;
    logic [EB-1:0]  r_rd_e;
    logic           r_res_cov;
    logic [VB-1:0]  r_res_avail;
    logic           r_res_ovf;
    logic           r_out_valid;
    logic           r_out_cov;
    logic [VB-1:0]  r_out_avail;
    logic           r_out_ovf;

    logic [CW-1:0]  w_km1;
    logic [CW-1:0]  w_rd_idx;
    logic [CW-1:0]  w_wr_idx;
    logic [AW-1:0]  w_rd_addr;
    logic [AW-1:0]  w_wr_addr;
    logic [OB-1:0]  w_wr_s;
    logic [EB-1:0]  w_wr_e;
    logic [EB-1:0]  w_off_x;

    assign w_km1     = r_k - CW'(1);
    assign w_rd_idx  = i_cmd.rd_k ? w_km1 : r_j;
    assign w_wr_idx  = i_cmd.wr_new ? r_i : r_k;
    assign w_rd_addr = w_rd_idx[AW-1:0];
    assign w_wr_addr = w_wr_idx[AW-1:0];
    assign w_wr_s    = i_cmd.wr_new ? r_s : r_rd_s;
    assign w_wr_e    = i_cmd.wr_new ? r_e : r_rd_e;
    assign w_off_x   = {1'b0, r_off};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_start[w_wr_addr] <= w_wr_s;
            mem_end[w_wr_addr]   <= w_wr_e;
        end
        if (i_cmd.rd_en) begin
            r_rd_s <= mem_start[w_rd_addr];
            r_rd_e <= mem_end[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_cnt) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_from_k) begin
                r_cnt <= r_k;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode      <= i_mode;
            r_off       <= i_offset;
            r_s         <= i_offset;
            r_e         <= {1'b0, i_offset} + {1'b0, i_length};
            r_len_zero  <= (i_length == '0);
            r_j         <= '0;
            r_res_cov   <= 1'b0;
            r_res_avail <= '0;
            r_res_ovf   <= 1'b0;
        end else begin
            if (i_cmd.j_inc) begin
                r_j <= r_j + CW'(1);
            end
            if (i_cmd.merge) begin
                if (r_rd_s < r_s) begin
                    r_s <= r_rd_s;
                end
                if (r_rd_e > r_e) begin
                    r_e <= r_rd_e;
                end
            end
            if (i_cmd.set_cov) begin
                r_res_cov <= 1'b1;
            end
            if (i_cmd.set_avail) begin
                r_res_avail <= VB'(r_rd_e - w_off_x);
            end
            if (i_cmd.set_ovf) begin
                r_res_ovf <= 1'b1;
            end
        end
        if (i_cmd.set_i) begin
            r_i <= r_j;
        end
        if (i_cmd.k_from_n) begin
            r_k <= r_cnt;
        end else if (i_cmd.k_from_i1) begin
            r_k <= r_i + CW'(1);
        end else if (i_cmd.k_dec) begin
            r_k <= w_km1;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.out_load) begin
            r_out_cov   <= r_res_cov;
            r_out_avail <= r_res_avail;
            r_out_ovf   <= r_res_ovf;
        end
    end

    always_comb begin
        o_sts.mode      = r_mode;
        o_sts.len_zero  = r_len_zero;
        o_sts.j_end     = (r_j >= r_cnt);
        o_sts.k_eq_i    = (r_k == r_i);
        o_sts.full      = (r_cnt >= CW'(MAX_RANGES));
        o_sts.rd_e_lt_s = (r_rd_e < {1'b0, r_s});
        o_sts.rd_s_le_e = ({1'b0, r_rd_s} <= r_e);
        o_sts.hit_cov   = (r_rd_s <= r_off) && (r_rd_e >= r_e);
        o_sts.hit_avail = (r_rd_s <= r_off) && (r_rd_e > w_off_x);
        o_sts.past      = (r_rd_s > r_off);
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_covered         = r_out_cov;
    assign o_available_bytes = r_out_avail;
    assign o_overflow        = r_out_ovf;

endmodule
`default_nettype wire

>>> hdl/ict_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ict_ctrl: operation sequencer of the interval coverage tracker
// Steps scan, merge, shift-up and compaction over the range table.
// ----------------------------------------------------------------------------
module ict_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  ict_pkg::t_dp_sts  i_sts,
    output ict_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_SC_RD  = 4'd2;
    localparam logic [3:0] ST_SC_EV  = 4'd3;
    localparam logic [3:0] ST_MG_RD  = 4'd4;
    localparam logic [3:0] ST_MG_EV  = 4'd5;
    localparam logic [3:0] ST_SH_RD  = 4'd6;
    localparam logic [3:0] ST_SH_WR  = 4'd7;
    localparam logic [3:0] ST_WR_NEW = 4'd8;
    localparam logic [3:0] ST_CP_NEW = 4'd9;
    localparam logic [3:0] ST_CP_RD  = 4'd10;
    localparam logic [3:0] ST_CP_WR  = 4'd11;
    localparam logic [3:0] ST_RESULT = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_sts.mode)
                    ict_pkg::MODE_ADD: begin
                        n_state = i_sts.len_zero ? ST_RESULT : ST_SC_RD;
                    end
                    ict_pkg::MODE_CONTAINS: begin
                        if (i_sts.len_zero) begin
                            o_cmd.set_cov = 1'b1;
                            n_state       = ST_RESULT;
                        end else begin
                            n_state = ST_SC_RD;
                        end
                    end
                    ict_pkg::MODE_AVAILABLE: begin
                        n_state = ST_SC_RD;
                    end
                    ict_pkg::MODE_CLEAR: begin
                        o_cmd.clr_cnt = 1'b1;
                        n_state       = ST_RESULT;
                    end
                    default: n_state = ST_RESULT;
                endcase
            end
            ST_SC_RD: begin
                if (i_sts.j_end) begin
                    if (i_sts.mode == ict_pkg::MODE_ADD) begin
                        // no entry ends at or past the new start: append
                        o_cmd.set_i = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.set_ovf = 1'b1;
                            n_state       = ST_RESULT;
                        end else begin
                            o_cmd.k_from_n = 1'b1;
                            n_state        = ST_SH_RD;
                        end
                    end else begin
                        n_state = ST_RESULT;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_SC_EV;
                end
            end
            ST_SC_EV: begin
                unique case (i_sts.mode)
                    ict_pkg::MODE_ADD: begin
                        if (i_sts.rd_e_lt_s) begin
                            o_cmd.j_inc = 1'b1;
                            n_state     = ST_SC_RD;
                        end else begin
                            o_cmd.set_i = 1'b1;
                            if (i_sts.rd_s_le_e) begin
                                o_cmd.merge = 1'b1;
                                o_cmd.j_inc = 1'b1;
                                n_state     = ST_MG_RD;
                            end else if (i_sts.full) begin
                                o_cmd.set_ovf = 1'b1;
                                n_state       = ST_RESULT;
                            end else begin
                                o_cmd.k_from_n = 1'b1;
                                n_state        = ST_SH_RD;
                            end
                        end
                    end
                    ict_pkg::MODE_CONTAINS: begin
                        if (i_sts.hit_cov) begin
                            o_cmd.set_cov = 1'b1;
                            n_state       = ST_RESULT;
                        end else if (i_sts.past) begin
                            n_state = ST_RESULT;
                        end else begin
                            o_cmd.j_inc = 1'b1;
                            n_state     = ST_SC_RD;
                        end
                    end
                    ict_pkg::MODE_AVAILABLE: begin
                        if (i_sts.hit_avail) begin
                            o_cmd.set_avail = 1'b1;
                            n_state         = ST_RESULT;
                        end else if (i_sts.past) begin
                            n_state = ST_RESULT;
                        end else begin
                            o_cmd.j_inc = 1'b1;
                            n_state     = ST_SC_RD;
                        end
                    end
                    default: n_state = ST_RESULT;
                endcase
            end
            ST_MG_RD: begin
                if (i_sts.j_end) begin
                    n_state = ST_CP_NEW;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_MG_EV;
                end
            end
            ST_MG_EV: begin
                if (i_sts.rd_s_le_e) begin
                    o_cmd.merge = 1'b1;
                    o_cmd.j_inc = 1'b1;
                    n_state     = ST_MG_RD;
                end else begin
                    n_state = ST_CP_NEW;
                end
            end
            ST_SH_RD: begin
                if (i_sts.k_eq_i) begin
                    n_state = ST_WR_NEW;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_k  = 1'b1;
                    n_state     = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.k_dec = 1'b1;
                n_state     = ST_SH_RD;
            end
            ST_WR_NEW: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_new  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = ST_RESULT;
            end
            ST_CP_NEW: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_new    = 1'b1;
                o_cmd.k_from_i1 = 1'b1;
                n_state         = ST_CP_RD;
            end
            ST_CP_RD: begin
                if (i_sts.j_end) begin
                    o_cmd.cnt_from_k = 1'b1;
                    n_state          = ST_RESULT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_CP_WR;
                end
            end
            ST_CP_WR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.j_inc = 1'b1;
                o_cmd.k_inc = 1'b1;
                n_state     = ST_CP_RD;
            end
            ST_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/interval_coverage_tracker.sv
`default_nettype none
// The tracker holds up to MAX_RANGES disjoint, sorted half-open byte ranges
// and runs one operation per request beat: add (with merging), contains,
// available-from or clear, each giving one result beat. Requests are taken
// one at a time; the table sits in a single-port memory with registered
// read data, so a scan visits each entry in a read state and an evaluate
// state, and an insert or a merge compaction moves each entry in a read
// state and a write state. A new request is taken while the previous
// result beat still waits on o_result.
// ----------------------------------------------------------------------------
// interval_coverage_tracker: sorted byte-range table with merge on insert
// Controller and datapath joined by command and status groups.
// ----------------------------------------------------------------------------
module interval_coverage_tracker #(
    parameter int MAX_RANGES = ict_pkg::MAX_RANGES_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ict_item_if.sink     i_item,
    ict_result_if.source o_result
);

    ict_pkg::t_dp_cmd w_cmd;
    ict_pkg::t_dp_sts w_sts;
    logic             w_in_ready;
    logic             w_out_valid;

    assign i_item.ready   = w_in_ready;
    assign o_result.valid = w_out_valid;

    ict_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ict_datapath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_mode            (i_item.mode),
        .i_offset          (i_item.offset),
        .i_length          (i_item.length),
        .i_out_ready       (o_result.ready),
        .o_out_valid       (w_out_valid),
        .o_covered         (o_result.covered),
        .o_available_bytes (o_result.available_bytes),
        .o_overflow        (o_result.overflow)
    );

endmodule
`default_nettype wire

>>> verif/tb_interval_coverage_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interval_coverage_tracker: self-checking bench for the range tracker
// A queue-fed driver sends add, contains, available and clear requests. A
// shadow copy of the sorted range table predicts every result beat, and the
// monitor checks each field. Both sides idle at random, and the result side
// holds off for long stretches so that the request side backs up.
// ----------------------------------------------------------------------------
module tb_interval_coverage_tracker;
    import ict_pkg::*;

    localparam int MAXR       = MAX_RANGES_DEF;
    localparam int N_RANDOM   = 900;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_CYC  = 4 * MAXR + 16;

    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic [OFFSET_BITS-1:0] offset;
        logic [OFFSET_BITS-1:0] length;
    } t_span_req;

    typedef struct packed {
        logic                  covered;
        logic [AVAIL_BITS-1:0] avail;
        logic                  overflow;
    } t_span_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ict_item_if   item_ch ();
    ict_result_if res_ch ();

    interval_coverage_tracker DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_span_req    request_backlog[$];
    t_span_result awaited_results[$];

    // shadow range table
    logic [OFFSET_BITS-1:0] span_lo [MAXR];
    logic [END_BITS-1:0]    span_hi [MAXR];
    int                     span_cnt = 0;

    int errors       = 0;
    int results_seen = 0;
    int hold_at      = 150;
    int hold_left    = 0;
    int in_gap       = 0;
    int out_stall    = 0;
    int idle_cycles  = 0;

    logic [OFFSET_BITS-1:0] win_base;

    function automatic t_span_result tracker_apply(t_span_req rq);
        t_span_result        r;
        logic [END_BITS-1:0] s;
        logic [END_BITS-1:0] e;
        int                  i;
        int                  j;
        int                  k;
        int                  absorbed;
        r = '0;
        s = {1'b0, rq.offset};
        e = {1'b0, rq.offset} + {1'b0, rq.length};
        case (rq.mode)
            MODE_ADD: begin
                if (rq.length != '0) begin
                    i = 0;
                    while (i < span_cnt && span_hi[i] < s) i++;
                    j = i;
                    while (j < span_cnt && {1'b0, span_lo[j]} <= e) begin
                        if ({1'b0, span_lo[j]} < s) s = {1'b0, span_lo[j]};
                        if (span_hi[j] > e) e = span_hi[j];
                        j++;
                    end
                    absorbed = j - i;
                    if (absorbed == 0 && span_cnt >= MAXR) begin
                        r.overflow = 1'b1;
                    end else begin
                        if (absorbed == 0) begin
                            for (k = span_cnt; k > i; k--) begin
                                span_lo[k] = span_lo[k-1];
                                span_hi[k] = span_hi[k-1];
                            end
                            span_cnt++;
                        end else begin
                            for (k = 0; j + k < span_cnt; k++) begin
                                span_lo[i+1+k] = span_lo[j+k];
                                span_hi[i+1+k] = span_hi[j+k];
                            end
                            span_cnt = span_cnt - absorbed + 1;
                        end
                        span_lo[i] = s[OFFSET_BITS-1:0];
                        span_hi[i] = e;
                    end
                end
            end
            MODE_CONTAINS: begin
                if (rq.length == '0) begin
                    r.covered = 1'b1;
                end else begin
                    for (i = 0; i < span_cnt; i++) begin
                        if (span_lo[i] <= rq.offset && span_hi[i] >= e) begin
                            r.covered = 1'b1;
                            break;
                        end
                        if (span_lo[i] > rq.offset) break;
                    end
                end
            end
            MODE_AVAILABLE: begin
                for (i = 0; i < span_cnt; i++) begin
                    if (span_lo[i] <= rq.offset && span_hi[i] > {1'b0, rq.offset}) begin
                        r.avail = span_hi[i] - {1'b0, rq.offset};
                        break;
                    end
                    if (span_lo[i] > rq.offset) break;
                end
            end
            default: span_cnt = 0;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] rand40();
        logic [OFFSET_BITS-1:0] v;
        v[31:0]             = $urandom;
        v[OFFSET_BITS-1:32] = (OFFSET_BITS-32)'($urandom);
        return v;
    endfunction

    task automatic queue_req(logic [MODE_BITS-1:0] m, logic [OFFSET_BITS-1:0] off,
                             logic [OFFSET_BITS-1:0] len);
        t_span_req rq;
        rq.mode   = m;
        rq.offset = off;
        rq.length = len;
        request_backlog.push_back(rq);
    endtask

    task automatic new_window();
        win_base                    = rand40();
        win_base[OFFSET_BITS-1:32] = (OFFSET_BITS-32)'($urandom_range(0, 254));
    endtask

    task automatic build_stimulus();
        int                     n;
        int                     r;
        logic [MODE_BITS-1:0]   m;
        logic [OFFSET_BITS-1:0] off;
        logic [OFFSET_BITS-1:0] len;
        // empty table, zero-length cases, adjacent merges, top of the offset range
        queue_req(MODE_CONTAINS, '0, '0);
        queue_req(MODE_AVAILABLE, 40'd5, '1);
        queue_req(MODE_ADD, 40'd100, '0);
        queue_req(MODE_ADD, 40'd100, 40'd50);
        queue_req(MODE_ADD, 40'd150, 40'd10);
        queue_req(MODE_ADD, 40'd90, 40'd10);
        queue_req(MODE_CONTAINS, 40'd90, 40'd71);
        queue_req(MODE_AVAILABLE, 40'd120, '1);
        queue_req(MODE_ADD, '1, '1);
        queue_req(MODE_AVAILABLE, '1, '0);
        queue_req(MODE_CLEAR, '0, '0);
        // fill the table, then a dropped add and a merging add while full
        for (n = 0; n < MAXR; n++) queue_req(MODE_ADD, 40'd1000 + 40'(n * 20), 40'd10);
        queue_req(MODE_ADD, 40'd5000, 40'd4);
        queue_req(MODE_ADD, 40'd1010, 40'd10);
        queue_req(MODE_CLEAR, '1, '1);

        new_window();
        for (n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 199) < 4) begin
                queue_req(MODE_CLEAR, rand40(), rand40());
                new_window();
                continue;
            end
            r = $urandom_range(0, 99);
            m = (r < 48) ? MODE_ADD : (r < 74) ? MODE_CONTAINS : MODE_AVAILABLE;
            if ($urandom_range(0, 99) < 8) begin
                off = rand40();
                len = rand40();
                if ($urandom_range(0, 1) == 0) len = len >> $urandom_range(1, 39);
            end else begin
                off = win_base + 40'($urandom_range(0, 63) * 16 + $urandom_range(0, 3));
                r   = $urandom_range(0, 99);
                if (m == MODE_ADD)
                    len = (r < 5) ? '0 : (r < 85) ? 40'($urandom_range(1, 14))
                                                  : 40'($urandom_range(15, 80));
                else
                    len = 40'($urandom_range(0, 24));
            end
            queue_req(m, off, len);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : req_drive
        t_span_req rq;
        int        g;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            in_gap = 0;
        end else begin
            g = in_gap;
            if (item_ch.valid && item_ch.ready) begin
                rq.mode   = item_ch.mode;
                rq.offset = item_ch.offset;
                rq.length = item_ch.length;
                awaited_results.push_back(tracker_apply(rq));
                g = pick_gap();
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (g > 0) begin
                    item_ch.valid <= 1'b0;
                    g--;
                end else if (request_backlog.size() != 0) begin
                    rq = request_backlog.pop_front();
                    item_ch.mode   <= rq.mode;
                    item_ch.offset <= rq.offset;
                    item_ch.length <= rq.length;
                    item_ch.valid  <= 1'b1;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
            in_gap = g;
        end
    end

    // long hold-off on the result side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (results_seen >= hold_at) begin
            hold_left <= HOLD_LEN;
            hold_at   <= hold_at + 450;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : res_check
        t_span_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected beat covered=%0b avail=%0d overflow=%0b",
                             $time, res_ch.covered, res_ch.available_bytes, res_ch.overflow);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (res_ch.covered !== want.covered) begin
                        $display("%0t: covered exp %0b got %0b",
                                 $time, want.covered, res_ch.covered);
                        errors++;
                    end
                    if (res_ch.available_bytes !== want.avail) begin
                        $display("%0t: available_bytes exp %0d got %0d",
                                 $time, want.avail, res_ch.available_bytes);
                        errors++;
                    end
                    if (res_ch.overflow !== want.overflow) begin
                        $display("%0t: overflow exp %0b got %0b",
                                 $time, want.overflow, res_ch.overflow);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
            end else if (out_stall > 0) begin
                res_ch.ready <= 1'b0;
                out_stall--;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25) out_stall = pick_gap();
            end
        end
    end

    // watchdog: cycles without any beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_interval_coverage_tracker: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        item_ch.valid  = 1'b0;
        item_ch.mode   = MODE_CLEAR;
        item_ch.offset = '0;
        item_ch.length = '0;
        res_ch.ready   = 1'b0;
        build_stimulus();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (request_backlog.size() != 0 || item_ch.valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("tb_interval_coverage_tracker: PASS");
        end else begin
            $display("tb_interval_coverage_tracker: FAIL");
        end
        $finish;
    end

endmodule
